// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes and controller-to-datapath command type of the stable
// priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // command from the controller to the cell array
  typedef struct packed {
    logic load;  // capture a new result into the output register
    logic enq;   // insert the request word into its sorted slot
    logic deq;   // pop the head and move every cell up one slot
  } dp_cmd_t;

endpackage

// File: design/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: operation code, element and signed priority.
// ----------------------------------------------------------------------------
interface spq_req_if #(
  parameter int DATA_BITS = 32,
  parameter int PRIO_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [DATA_BITS-1:0]        element;
  logic signed [PRIO_BITS-1:0] priority_req;

  modport source (output valid, op, element, priority_req, input ready);
  modport sink   (input valid, op, element, priority_req, output ready);
endinterface

// File: design/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: removed entry, status code and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if #(
  parameter int DATA_BITS = 32,
  parameter int PRIO_BITS = 16,
  parameter int CNT_BITS  = 5
);
  logic                        valid;
  logic                        ready;
  logic [DATA_BITS-1:0]        out_element;
  logic signed [PRIO_BITS-1:0] out_priority;
  logic                        out_valid;
  logic [1:0]                  status;
  logic [CNT_BITS-1:0]         count;

  modport source (output valid, out_element, out_priority, out_valid, status, count,
                  input ready);
  modport sink   (input valid, out_element, out_priority, out_valid, status, count,
                  output ready);
endinterface

// File: design/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Sorted cell array: every cell compares its priority with the request in
// parallel, then holds, loads the new entry, or shifts down or up one slot.
// ----------------------------------------------------------------------------
module spq_dpath #(
  parameter int DEPTH     = 16,
  parameter int DATA_BITS = 32,
  parameter int PRIO_BITS = 16,
  parameter int CNT_BITS  = 5
) (
  input  logic                        clk_i,
  input  spq_pkg::dp_cmd_t            cmd_i,
  input  logic [CNT_BITS-1:0]         occ_i,
  input  logic [DATA_BITS-1:0]        element_i,
  input  logic signed [PRIO_BITS-1:0] prio_i,
  output logic [DATA_BITS-1:0]        elem_o,
  output logic signed [PRIO_BITS-1:0] prio_o
);
  import spq_pkg::*;

  logic [DATA_BITS-1:0]        data_q [DEPTH];
  logic signed [PRIO_BITS-1:0] prio_q [DEPTH];
  logic [DEPTH-1:0]            ge;
  logic [DATA_BITS-1:0]        elem_q;
  logic signed [PRIO_BITS-1:0] oprio_q;

  // held entries that stay ahead of the new one form a prefix of ones
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign ge[i] = (CNT_BITS'(i) < occ_i) && (prio_q[i] >= prio_i);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic ins_here;
    logic from_above;
    if (i == 0) begin : g_head
      assign ins_here   = !ge[0];
      assign from_above = 1'b0;
    end else begin : g_body
      assign ins_here   = !ge[i] && ge[i-1];
      assign from_above = !ge[i] && !ge[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.enq) begin
        if (ins_here) begin
          data_q[i] <= element_i;
          prio_q[i] <= prio_i;
        end else if (from_above) begin
          data_q[i] <= data_q[(i == 0) ? 0 : i-1];
          prio_q[i] <= prio_q[(i == 0) ? 0 : i-1];
        end
      end else if (cmd_i.deq && (i < DEPTH-1)) begin
        data_q[i] <= data_q[(i < DEPTH-1) ? i+1 : i];
        prio_q[i] <= prio_q[(i < DEPTH-1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      elem_q  <= cmd_i.deq ? data_q[0] : '0;
      oprio_q <= cmd_i.deq ? prio_q[0] : '0;
    end
  end

  assign elem_o = elem_q;
  assign prio_o = oprio_q;

endmodule

// File: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: decodes the operation, keeps the occupancy, issues cell array
// commands and holds the response status until it is taken.
// ----------------------------------------------------------------------------
module spq_ctrl #(
  parameter int DEPTH    = 16,
  parameter int CNT_BITS = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic [1:0]          op_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic                fld_valid_o,
  output logic [1:0]          status_o,
  output logic [CNT_BITS-1:0] occ_o,
  output spq_pkg::dp_cmd_t    cmd_o
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;
  localparam logic [CNT_BITS-1:0] FullCnt = CNT_BITS'(DEPTH);

  logic                state_q, state_d;
  logic [CNT_BITS-1:0] occ_q, occ_d;
  status_e             status_q, status_d;
  logic                fval_q, fval_d;
  logic                accept;

  // a pending response may leave in the same cycle a new request enters
  assign req_ready_o = (state_q == S_IDLE) || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    status_d   = status_q;
    fval_d     = fval_q;
    cmd_o      = '0;
    cmd_o.load = accept;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_RESP;
      S_RESP: if (rsp_ready_i && !accept) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (accept) begin
      status_d = ST_OK;
      fval_d   = 1'b0;
      unique case (op_i)
        OP_ENQUEUE: begin
          if (occ_q == FullCnt) begin
            status_d = ST_OVERFLOW;
          end else begin
            cmd_o.enq = 1'b1;
            occ_d     = occ_q + 1'b1;
          end
        end
        OP_DEQUEUE: begin
          if (occ_q == '0) begin
            status_d = ST_UNDERFLOW;
          end else begin
            cmd_o.deq = 1'b1;
            fval_d    = 1'b1;
            occ_d     = occ_q - 1'b1;
          end
        end
        OP_CLEAR: occ_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      status_q <= ST_OK;
      fval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      status_q <= status_d;
      fval_q   <= fval_d;
    end
  end

  assign rsp_valid_o = (state_q == S_RESP);
  assign fld_valid_o = fval_q;
  assign status_o    = status_q;
  assign occ_o       = occ_q;

endmodule

// File: design/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue in descending priority order, ties first in first out.
// ----------------------------------------------------------------------------
// response: valid in the cycle after its request transfer
// throughput: one operation per cycle while responses are taken at once; all
//   cells compare against the new priority in parallel, so DEPTH sets the
//   width of that compare and the single output register sets the pacing
// reset: clears occupancy and response state; stored and output entries not reset
module stable_priority_queue_core #(
  parameter int DEPTH     = 16,
  parameter int DATA_BITS = 32,
  parameter int PRIO_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  dp_cmd_t                     cmd;
  logic [CNT_BITS-1:0]         occ;
  logic                        fld_valid;
  logic [1:0]                  status;
  logic [DATA_BITS-1:0]        elem;
  logic signed [PRIO_BITS-1:0] prio;

  spq_ctrl #(
    .DEPTH    (DEPTH),
    .CNT_BITS (CNT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .op_i        (req_i.op),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .fld_valid_o (fld_valid),
    .status_o    (status),
    .occ_o       (occ),
    .cmd_o       (cmd)
  );

  spq_dpath #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS),
    .PRIO_BITS (PRIO_BITS),
    .CNT_BITS  (CNT_BITS)
  ) u_dpath (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .occ_i     (occ),
    .element_i (req_i.element),
    .prio_i    (req_i.priority_req),
    .elem_o    (elem),
    .prio_o    (prio)
  );

  assign rsp_o.out_element  = elem;
  assign rsp_o.out_priority = prio;
  assign rsp_o.out_valid    = fld_valid;
  assign rsp_o.status       = status;
  assign rsp_o.count        = occ;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= CNT_BITS'(DEPTH))
    else $error("occupancy above depth");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.out_valid |-> rsp_o.status == ST_OK)
    else $error("entry returned with error status");

  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && req_i.op == OP_DEQUEUE && occ == '0
    |=> rsp_o.status == ST_UNDERFLOW && !rsp_o.out_valid)
    else $error("empty dequeue not flagged");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> req_i.ready)
    else $error("request stalled with no pending response");

endmodule
